[hdl/hec_pkg.sv]
package hec_pkg;

    localparam int CODE_W            = 64;
    localparam int LEN_W             = 7;
    localparam int SYN_W             = 7;
    localparam int DLEN_W            = 6;
    localparam int PAR_W             = 3;
    localparam int PAR_MAX           = 7;
    localparam int DEF_MAX_CODE_BITS = 64;
    localparam int DEF_DATA_LEN      = 4;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_CHECK  = 1'b1
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } ctl_t;

    // smallest p with 2^p - p - 1 >= d, capped at PAR_MAX
    function automatic int parity_count_int(input int d);
        int p;
        p = 0;
        for (int i = 0; i < PAR_MAX; i++)
        begin
            if (((1 << i) - i - 1) < d)
            begin
                p = i + 1;
            end
        end
        return p;
    endfunction

    function automatic logic [PAR_W-1:0] parity_count(input logic [DLEN_W-1:0] d);
        logic [PAR_W-1:0] p;
        p = '0;
        for (int i = 0; i < PAR_MAX; i++)
        begin
            if (DLEN_W'(((1 << i) - i - 1)) < d)
            begin
                p = PAR_W'(i + 1);
            end
        end
        return p;
    endfunction

    // largest data length whose codeword still fits in max_bits, at least 1
    function automatic int max_data_len(input int max_bits);
        int r;
        r = 1;
        for (int d = 1; d < (1 << DLEN_W); d++)
        begin
            if (d + parity_count_int(d) <= max_bits)
            begin
                r = d;
            end
        end
        return r;
    endfunction

    // codeword bits (bit k is position k+1) covered by parity bit i, itself excluded
    function automatic logic [CODE_W-1:0] cover_mask(input int i);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int pos = 1; pos <= CODE_W; pos++)
        begin
            if ((((pos >> i) & 1) != 0) && (pos != (1 << i)))
            begin
                m[pos-1] = 1'b1;
            end
        end
        return m;
    endfunction

    // bit index in the codeword of data bit k; CODE_W when it falls off the end
    function automatic int data_pos(input int k);
        int cnt;
        int r;
        cnt = 0;
        r   = CODE_W;
        for (int pos = 1; pos <= CODE_W; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                if (cnt == k)
                begin
                    r = pos - 1;
                end
                cnt++;
            end
        end
        return r;
    endfunction

endpackage

[hdl/hamming_encode_and_check.sv]
// A request's result reaches done through the input, mask, parity and result registers in turn.
// Throughput: one request per cycle, every cycle; busy stays low.
// Stages: input register, mask and scatter, parity trees, result assembly.
// Reset: asynchronous, active low; clears all valid bits, sets data length to min(4, DMAX).
// The receiver cannot stall: each result is on the ports for one cycle only.
module hamming_encode_and_check
    import hec_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DLEN_W-1:0]  cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [CODE_W-1:0]  data_word,
    output logic               done,
    output logic [CODE_W-1:0]  code_word,
    output logic [LEN_W-1:0]   code_length,
    output logic [SYN_W-1:0]   syndrome,
    output logic               error_found
);

    localparam int DMAX = max_data_len(MAX_CODE_BITS);
    localparam int RST_D = (DEF_DATA_LEN < DMAX) ? DEF_DATA_LEN : DMAX;
    localparam logic [DLEN_W-1:0] DMAX_V    = DLEN_W'(DMAX);
    localparam logic [DLEN_W-1:0] RST_DLEN  = DLEN_W'(RST_D);
    localparam logic [PAR_W-1:0]  RST_PCNT  = PAR_W'(parity_count_int(RST_D));
    localparam logic [LEN_W-1:0]  RST_CLEN  = LEN_W'(RST_D + parity_count_int(RST_D));

    // geometry, settled once per configuration write
    logic [DLEN_W-1:0] dlen_reg;
    logic [DLEN_W-1:0] dlen_next;
    logic [PAR_W-1:0]  pcnt_reg;
    logic [PAR_W-1:0]  pcnt_next;
    logic [LEN_W-1:0]  clen_reg;
    logic [LEN_W-1:0]  clen_next;

    always_comb
    begin
        priority if (cfg_wdata == '0)
        begin
            dlen_next = DLEN_W'(1);
        end
        else if (cfg_wdata > DMAX_V)
        begin
            dlen_next = DMAX_V;
        end
        else
        begin
            dlen_next = cfg_wdata;
        end
        pcnt_next = parity_count(dlen_next);
        clen_next = LEN_W'(dlen_next) + LEN_W'(pcnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlen_reg <= RST_DLEN;
            pcnt_reg <= RST_PCNT;
            clen_reg <= RST_CLEN;
        end
        else if (cfg_we)
        begin
            dlen_reg <= dlen_next;
            pcnt_reg <= pcnt_next;
            clen_reg <= clen_next;
        end
    end

    assign busy = 1'b0;

    // stage 1: capture the request
    ctl_t              s1_ctl_reg;
    logic [CODE_W-1:0] s1_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg.valid <= start && !busy;
            s1_ctl_reg.req   <= req_t'(req_type);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= data_word;
    end

    // stage 2: drop bits past the data or codeword length, spread data bits
    ctl_t              s2_ctl_reg;
    logic [CODE_W-1:0] s2_word_reg;
    logic [CODE_W-1:0] s2_word_next;
    logic [LEN_W-1:0]  keep_len;
    logic [CODE_W-1:0] keep_mask;
    logic [CODE_W-1:0] kept;
    logic [CODE_W-1:0] spread;

    always_comb
    begin
        keep_len = (s1_ctl_reg.req == REQ_CHECK) ? clen_reg : LEN_W'(dlen_reg);
        for (int j = 0; j < CODE_W; j++)
        begin
            keep_mask[j] = LEN_W'(j) < keep_len;
        end
        kept   = s1_word_reg & keep_mask;
        spread = '0;
        for (int k = 0; k < CODE_W; k++)
        begin
            if (data_pos(k) < CODE_W)
            begin
                spread[data_pos(k)] = kept[k];
            end
        end
        s2_word_next = (s1_ctl_reg.req == REQ_CHECK) ? kept : spread;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_word_reg <= s2_word_next;
    end

    // stage 3: parity trees
    ctl_t               s3_ctl;
    logic [CODE_W-1:0]  s3_word;
    logic [PAR_MAX-1:0] s3_calc;
    logic [PAR_MAX-1:0] s3_got;

    hec_parity u_parity (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (s2_ctl_reg),
        .in_word  (s2_word_reg),
        .out_ctl  (s3_ctl),
        .out_word (s3_word),
        .out_calc (s3_calc),
        .out_got  (s3_got)
    );

    // stage 4: assemble the result
    logic               done_reg;
    logic [CODE_W-1:0]  cw_reg;
    logic [CODE_W-1:0]  cw_next;
    logic [SYN_W-1:0]   synd_reg;
    logic [SYN_W-1:0]   synd_next;
    logic               err_reg;
    logic [PAR_MAX-1:0] par_en;

    always_comb
    begin
        for (int i = 0; i < PAR_MAX; i++)
        begin
            par_en[i] = PAR_W'(i) < pcnt_reg;
        end
        cw_next   = '0;
        synd_next = '0;
        unique case (s3_ctl.req)
            REQ_ENCODE:
            begin
                cw_next = s3_word;
                for (int i = 0; i < PAR_MAX; i++)
                begin
                    if (par_en[i])
                    begin
                        cw_next[(1 << i) - 1] = s3_calc[i];
                    end
                end
            end
            REQ_CHECK:
            begin
                // syndrome bit i stands for parity position 2^i
                synd_next = SYN_W'(par_en & (s3_calc ^ s3_got));
            end
            default:
            begin
                cw_next   = '0;
                synd_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg   <= cw_next;
        synd_reg <= synd_next;
        err_reg  <= synd_next != '0;
    end

    assign done        = done_reg;
    assign code_word   = cw_reg;
    assign code_length = clen_reg;
    assign syndrome    = synd_reg;
    assign error_found = err_reg;

    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("request did not produce a result after four cycles");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !done)
        else $error("result appeared without a request");

    a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((code_word == '0) || (syndrome == '0)))
        else $error("codeword and syndrome both nonzero in one result");

endmodule

[hdl/hec_parity.sv]
module hec_parity
    import hec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                in_ctl,
    input  logic [CODE_W-1:0]   in_word,
    output ctl_t                out_ctl,
    output logic [CODE_W-1:0]   out_word,
    output logic [PAR_MAX-1:0]  out_calc,
    output logic [PAR_MAX-1:0]  out_got
);

    ctl_t               ctl_reg;
    logic [CODE_W-1:0]  word_reg;
    logic [PAR_MAX-1:0] calc_reg;
    logic [PAR_MAX-1:0] got_reg;
    logic [PAR_MAX-1:0] calc_next;
    logic [PAR_MAX-1:0] got_next;

    // parity trees over fixed cover masks; bits past the codeword are already zero
    always_comb
    begin
        for (int i = 0; i < PAR_MAX; i++)
        begin
            calc_next[i] = ^(in_word & cover_mask(i));
            got_next[i]  = in_word[(1 << i) - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= in_word;
        calc_reg <= calc_next;
        got_reg  <= got_next;
    end

    assign out_ctl  = ctl_reg;
    assign out_word = word_reg;
    assign out_calc = calc_reg;
    assign out_got  = got_reg;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import hec_pkg::*;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_LENGTH,
        OP_DRAIN
    } pending_kind_t;

    typedef struct {
        pending_kind_t   kind;
        req_t            req;
        logic [CODE_W-1:0] word;
        logic [DLEN_W-1:0] length;
    } pending_op_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
        logic [SYN_W-1:0]  syndrome;
        logic              error_found;
    } hamming_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [DLEN_W-1:0]  cfg_wdata = '0;
    logic               start = 1'b0;
    logic               busy;
    logic               req_type = 1'b0;
    logic [CODE_W-1:0]  data_word = '0;
    logic               done;
    logic [CODE_W-1:0]  code_word;
    logic [LEN_W-1:0]   code_length;
    logic [SYN_W-1:0]   syndrome;
    logic               error_found;

    pending_op_t        pending_ops[$];
    hamming_result_t    awaited_results[$];
    int unsigned        mismatch_count = 0;
    int unsigned        requests_sent;
    logic [DLEN_W-1:0]  length_reg;
    logic [DLEN_W-1:0]  planned_length;
    pending_op_t        head_op;
    logic               start_next;
    logic               we_next;
    hamming_result_t    got_result;
    hamming_result_t    want_result;

    hamming_encode_and_check dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .data_word   (data_word),
        .done        (done),
        .code_word   (code_word),
        .code_length (code_length),
        .syndrome    (syndrome),
        .error_found (error_found)
    );

    always #5 clk = ~clk;

    function automatic int unsigned parity_bits(input int unsigned d);
        int unsigned p;
        p = 0;
        while (p < 7 && ((1 << p) - p - 1) < d)
        begin
            p++;
        end
        return p;
    endfunction

    // positions 1..len that parity position pv covers, pv itself left out
    function automatic logic [CODE_W-1:0] covered_positions(input int unsigned pv,
                                                            input int unsigned len);
        logic [CODE_W-1:0] m;
        int unsigned pos;
        m = '0;
        for (pos = 1; pos <= len; pos++)
        begin
            if ((pos & pv) != 0 && pos != pv)
            begin
                m[pos-1] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic hamming_result_t predict_hamming(input req_t kind,
                                                        input logic [CODE_W-1:0] word,
                                                        input logic [DLEN_W-1:0] length_value);
        hamming_result_t r;
        int unsigned d, p, len, pos, di, i, pv, synd;
        logic [CODE_W-1:0] cw, rx;
        d = length_value;
        if (d == 0)
        begin
            d = 1;
        end
        p = parity_bits(d);
        // shrink the data length until the codeword fits
        while (d > 1 && d + p > CODE_W)
        begin
            d--;
            p = parity_bits(d);
        end
        len  = d + p;
        cw   = '0;
        synd = 0;
        if (kind == REQ_ENCODE)
        begin
            di = 0;
            for (pos = 1; pos <= len; pos++)
            begin
                if ((pos & (pos - 1)) != 0)
                begin
                    cw[pos-1] = word[di];
                    di++;
                end
            end
            for (i = 0; i < p; i++)
            begin
                pv = 1 << i;
                cw[pv-1] = ^(cw & covered_positions(pv, len));
            end
        end
        else
        begin
            rx = word & ((64'd1 << len) - 64'd1);
            for (i = 0; i < p; i++)
            begin
                pv = 1 << i;
                if ((^(rx & covered_positions(pv, len))) != rx[pv-1])
                begin
                    synd += pv;
                end
            end
        end
        r.code_word   = cw;
        r.code_length = LEN_W'(len);
        r.syndrome    = SYN_W'(synd);
        r.error_found = (synd != 0);
        return r;
    endfunction

    task automatic queue_request(input req_t kind, input logic [CODE_W-1:0] word);
        pending_op_t op;
        op.kind   = OP_REQUEST;
        op.req    = kind;
        op.word   = word;
        op.length = '0;
        pending_ops.push_back(op);
    endtask

    task automatic queue_length_write(input logic [DLEN_W-1:0] value);
        pending_op_t op;
        op.kind   = OP_LENGTH;
        op.req    = REQ_ENCODE;
        op.word   = '0;
        op.length = value;
        pending_ops.push_back(op);
        planned_length = value;
    endtask

    task automatic queue_drain();
        pending_op_t op;
        op.kind   = OP_DRAIN;
        op.req    = REQ_ENCODE;
        op.word   = '0;
        op.length = '0;
        pending_ops.push_back(op);
    endtask

    // valid codeword for the planned length with some bits flipped
    function automatic logic [CODE_W-1:0] damaged_codeword(input logic [CODE_W-1:0] data,
                                                           input int unsigned flips);
        hamming_result_t enc;
        logic [CODE_W-1:0] cw;
        int unsigned n;
        enc = predict_hamming(REQ_ENCODE, data, planned_length);
        cw  = enc.code_word;
        for (n = 0; n < flips; n++)
        begin
            cw[$urandom_range(0, enc.code_length - 1)] ^= 1'b1;
        end
        return cw;
    endfunction

    task automatic report_field(input string name, input logic [CODE_W-1:0] want,
                                input logic [CODE_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // driver: holds a request until taken, writes the length register only when idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start         <= 1'b0;
            cfg_we        <= 1'b0;
            cfg_wdata     <= '0;
            req_type      <= REQ_ENCODE;
            data_word     <= '0;
            length_reg    = DLEN_W'(DEF_DATA_LEN);
            requests_sent = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                length_reg = cfg_wdata;
            end
            if (start && !busy)
            begin
                awaited_results.push_back(predict_hamming(req_t'(req_type), data_word,
                                                          length_reg));
                requests_sent++;
            end
            if (!start || !busy)
            begin
                start_next = 1'b0;
                we_next    = 1'b0;
                if (pending_ops.size() != 0)
                begin
                    case (pending_ops[0].kind)
                        OP_REQUEST:
                        begin
                            // idle now and then, except over one long stretch
                            if ((requests_sent < 400 || requests_sent >= 650) &&
                                $urandom_range(0, 99) < 14)
                            begin
                                start_next = 1'b0;
                            end
                            else
                            begin
                                head_op    = pending_ops.pop_front();
                                start_next = 1'b1;
                                req_type   <= head_op.req;
                                data_word  <= head_op.word;
                            end
                        end
                        OP_LENGTH:
                        begin
                            if (awaited_results.size() == 0 && !cfg_we)
                            begin
                                head_op   = pending_ops.pop_front();
                                we_next   = 1'b1;
                                cfg_wdata <= head_op.length;
                            end
                        end
                        default:
                        begin
                            if (awaited_results.size() == 0)
                            begin
                                head_op = pending_ops.pop_front();
                            end
                        end
                    endcase
                end
                start  <= start_next;
                cfg_we <= we_next;
            end
        end
    end

    // monitor: every done pulse must match the oldest awaited result
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_result.code_word   = code_word;
            got_result.code_length = code_length;
            got_result.syndrome    = syndrome;
            got_result.error_found = error_found;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         got_result);
            end
            else
            begin
                want_result = awaited_results.pop_front();
                report_field("code_word", want_result.code_word, got_result.code_word);
                report_field("code_length", want_result.code_length, got_result.code_length);
                report_field("syndrome", want_result.syndrome, got_result.syndrome);
                report_field("error_found", want_result.error_found, got_result.error_found);
            end
        end
    end

    initial
    begin
        hamming_result_t enc;
        logic [CODE_W-1:0] word;
        int unsigned phase, item, pick;
        logic [DLEN_W-1:0] phase_length;

        planned_length = DLEN_W'(DEF_DATA_LEN);

        // reset length of four
        queue_request(REQ_ENCODE, 64'h0);
        queue_request(REQ_ENCODE, 64'hF);
        queue_request(REQ_ENCODE, '1);
        queue_request(REQ_ENCODE, 64'h5);
        queue_request(REQ_CHECK, 64'h0);
        queue_request(REQ_CHECK, damaged_codeword(64'hB, 0));
        enc = predict_hamming(REQ_ENCODE, 64'hB, planned_length);
        queue_request(REQ_CHECK, enc.code_word ^ 64'h4);
        queue_request(REQ_CHECK, enc.code_word ^ 64'h1);
        queue_request(REQ_CHECK, '1);
        // zero acts as a single data bit
        queue_length_write(6'd0);
        queue_request(REQ_ENCODE, 64'h1);
        queue_request(REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_request(REQ_CHECK, 64'h7);
        queue_request(REQ_CHECK, 64'h1);
        // largest length that fits
        queue_length_write(6'd57);
        queue_request(REQ_ENCODE, '1);
        queue_request(REQ_ENCODE, 64'h0155_5555_5555_5555);
        enc = predict_hamming(REQ_ENCODE, '1, planned_length);
        queue_request(REQ_CHECK, enc.code_word ^ (64'd1 << 62));
        queue_request(REQ_CHECK, '1);
        queue_request(REQ_CHECK, 64'h0);
        // oversize lengths fold back to the largest one
        queue_length_write(6'd63);
        queue_request(REQ_ENCODE, '1);
        queue_request(REQ_CHECK, damaged_codeword({$urandom, $urandom}, 2));
        queue_length_write(6'd58);
        queue_request(REQ_ENCODE, 64'h01FF_FFFF_FFFF_FFFF);
        queue_length_write(6'd1);
        queue_request(REQ_ENCODE, 64'h1);
        queue_request(REQ_CHECK, 64'h4);

        for (phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: phase_length = 6'd57;
                1: phase_length = 6'd1;
                2: phase_length = 6'd63;
                3: phase_length = 6'd0;
                default: phase_length = DLEN_W'($urandom_range(0, 63));
            endcase
            queue_length_write(phase_length);
            for (item = 0; item < 100; item++)
            begin
                pick = $urandom_range(0, 99);
                word = {$urandom, $urandom};
                if (pick < 45)
                begin
                    queue_request(REQ_ENCODE, word);
                end
                else if (pick < 60)
                begin
                    queue_request(REQ_CHECK, word);
                end
                else
                begin
                    enc  = predict_hamming(REQ_ENCODE, word, planned_length);
                    word = damaged_codeword(word, $urandom_range(0, 2));
                    // junk above the codeword now and then
                    if ($urandom_range(0, 3) == 0)
                    begin
                        word |= {$urandom, $urandom} &
                                ~((64'd1 << enc.code_length) - 64'd1);
                    end
                    queue_request(REQ_CHECK, word);
                end
                if (item == 50)
                begin
                    queue_drain();
                end
            end
            queue_drain();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (pending_ops.size() != 0 || start || awaited_results.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
